@@ design/gtc_pkg.sv @@
`timescale 1ns / 1ps

package gtc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned TIMER_BITS_DEF = 24;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned LONG_W     = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CMP_W      = 33;

  localparam logic [VALUE_W-1:0] LIFT_ID = 32'hFFFF_FFFF;

  localparam logic             EN_RST   = 1'b0;
  localparam logic             MODE_RST = 1'b1;
  localparam logic [THR_W-1:0]  THR_RST  = 16'd10;
  localparam logic [LONG_W-1:0] LONG_RST = 24'd500;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_X    = 2'd1,
    FUNC_Y    = 2'd2,
    FUNC_ID   = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TAP   = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_SWIPE = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_MODE   = 2'd1,
    REG_THR    = 2'd2,
    REG_LONG   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              record_enable;
    logic              record_mode;
    logic [THR_W-1:0]  move_threshold;
    logic [LONG_W-1:0] long_press_ms;
    logic              clear_gap;
  } cfg_t;

endpackage

@@ design/touch_gesture_classifier.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser: func, tdata: event_value
// m_axis    out  tvalid/tready        tuser: gesture_kind, tdata: gesture record
// cfg       in   cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
//
// One item per cycle; a lift result shows on m_axis in the cycle after the lift item is taken.
// The rate is set by the single result register: s_axis_tready is low only
// while that register holds a result that m_axis_tready does not take.
// Asynchronous active-low reset returns all state and registers, except the output data register, to defaults.
// Configuration writes are taken every cycle.

module touch_gesture_classifier #(
  parameter int unsigned COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int unsigned TIMER_BITS = gtc_pkg::TIMER_BITS_DEF,
  localparam int unsigned OUT_RAW   = 4 * COORD_BITS + 2 * TIMER_BITS + 1,
  localparam int unsigned OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: event_value
  input  logic [gtc_pkg::VALUE_W-1:0]    s_axis_tdata,
  // tuser: func
  input  logic [gtc_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: start_x, start_y, end_x, end_y, duration_ms, delay_ms, mode_tag, zero pad
  output logic [OUT_W-1:0]               m_axis_tdata,
  // tuser: gesture_kind
  output logic [gtc_pkg::KIND_W-1:0]     m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gtc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gtc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STAGE_W = gtc_pkg::KIND_W + OUT_W;

  gtc_pkg::cfg_t               cfg;
  logic                        accept;
  logic                        res_valid;
  logic [gtc_pkg::KIND_W-1:0]  res_kind;
  logic [OUT_W-1:0]            res_data;
  logic [STAGE_W-1:0]          stage_out;

  assign accept = s_axis_tvalid & s_axis_tready;

  gtc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gtc_core #(
    .COORD_BITS (COORD_BITS),
    .TIMER_BITS (TIMER_BITS),
    .OUT_W      (OUT_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .func_i      (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_kind_o  (res_kind),
    .res_data_o  (res_data)
  );

  gtc_out_stage #(
    .WIDTH (STAGE_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   ({res_data, res_kind}),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (stage_out)
  );

  assign m_axis_tuser = stage_out[gtc_pkg::KIND_W-1:0];
  assign m_axis_tdata = stage_out[STAGE_W-1:gtc_pkg::KIND_W];

`ifndef ASSERT_OFF
  a_result_from_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(accept && (s_axis_tuser == gtc_pkg::FUNC_ID) &&
                                   (s_axis_tdata == gtc_pkg::LIFT_ID)))
    else $error("result without an accepted lift");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == gtc_pkg::KIND_TAP ||
                       m_axis_tuser == gtc_pkg::KIND_LONG ||
                       m_axis_tuser == gtc_pkg::KIND_SWIPE))
    else $error("illegal gesture kind");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == gtc_pkg::FUNC_TICK && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("tick produced a result");
`endif

endmodule

@@ design/gtc_cfg_regs.sv @@
`timescale 1ns / 1ps

module gtc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gtc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gtc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output gtc_pkg::cfg_t                    cfg_o
);

  logic                        enable_q, enable_d;
  logic                        mode_q, mode_d;
  logic [gtc_pkg::THR_W-1:0]   thr_q, thr_d;
  logic [gtc_pkg::LONG_W-1:0]  long_q, long_d;
  logic                        write;
  logic                        clear_gap;

  assign cfg_ready_o = 1'b1;
  assign write       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    enable_d  = enable_q;
    mode_d    = mode_q;
    thr_d     = thr_q;
    long_d    = long_q;
    clear_gap = 1'b0;
    if (write) begin
      case (gtc_pkg::cfg_idx_e'(cfg_index_i))
        gtc_pkg::REG_ENABLE: begin
          enable_d  = cfg_data_i[0];
          clear_gap = cfg_data_i[0];
        end
        gtc_pkg::REG_MODE: mode_d = cfg_data_i[0];
        gtc_pkg::REG_THR:  thr_d  = cfg_data_i[gtc_pkg::THR_W-1:0];
        gtc_pkg::REG_LONG: long_d = cfg_data_i[gtc_pkg::LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= gtc_pkg::EN_RST;
      mode_q   <= gtc_pkg::MODE_RST;
      thr_q    <= gtc_pkg::THR_RST;
      long_q   <= gtc_pkg::LONG_RST;
    end else begin
      enable_q <= enable_d;
      mode_q   <= mode_d;
      thr_q    <= thr_d;
      long_q   <= long_d;
    end
  end

  assign cfg_o.record_enable  = enable_q;
  assign cfg_o.record_mode    = mode_q;
  assign cfg_o.move_threshold = thr_q;
  assign cfg_o.long_press_ms  = long_q;
  assign cfg_o.clear_gap      = clear_gap;

endmodule

@@ design/gtc_core.sv @@
`timescale 1ns / 1ps

module gtc_core #(
  parameter int unsigned COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int unsigned TIMER_BITS = gtc_pkg::TIMER_BITS_DEF,
  parameter int unsigned OUT_W      = 120
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gtc_pkg::cfg_t                 cfg_i,
  input  logic                          accept_i,
  input  logic [gtc_pkg::FUNC_W-1:0]    func_i,
  input  logic [gtc_pkg::VALUE_W-1:0]   value_i,
  output logic                          res_valid_o,
  output logic [gtc_pkg::KIND_W-1:0]    res_kind_o,
  output logic [OUT_W-1:0]              res_data_o
);

  localparam int unsigned OUT_RAW = 4 * COORD_BITS + 2 * TIMER_BITS + 1;
  localparam int unsigned PAD_W   = OUT_W - OUT_RAW;

  logic [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [COORD_BITS-1:0] down_x_q, down_x_d, down_y_q, down_y_d;
  logic                  touching_q, touching_d;
  logic [TIMER_BITS-1:0] touch_q, touch_d, gap_q, gap_d;

  logic [COORD_BITS-1:0] coord, dx, dy;
  logic                  still, is_long, emit;
  gtc_pkg::kind_e        kind;

  assign coord = value_i[COORD_BITS-1:0];
  assign dx    = (last_x_q >= down_x_q) ? last_x_q - down_x_q : down_x_q - last_x_q;
  assign dy    = (last_y_q >= down_y_q) ? last_y_q - down_y_q : down_y_q - last_y_q;
  assign still = (gtc_pkg::CMP_W'(dx) < gtc_pkg::CMP_W'(cfg_i.move_threshold)) &&
                 (gtc_pkg::CMP_W'(dy) < gtc_pkg::CMP_W'(cfg_i.move_threshold));
  assign is_long = gtc_pkg::CMP_W'(touch_q) > gtc_pkg::CMP_W'(cfg_i.long_press_ms);

  always_comb begin
    if (!still) begin
      kind = gtc_pkg::KIND_SWIPE;
    end else if (is_long) begin
      kind = gtc_pkg::KIND_LONG;
    end else begin
      kind = gtc_pkg::KIND_TAP;
    end
  end

  always_comb begin
    last_x_d   = last_x_q;
    last_y_d   = last_y_q;
    down_x_d   = down_x_q;
    down_y_d   = down_y_q;
    touching_d = touching_q;
    touch_d    = touch_q;
    gap_d      = gap_q;
    emit       = 1'b0;
    if (accept_i) begin
      case (gtc_pkg::func_e'(func_i))
        gtc_pkg::FUNC_TICK: begin
          if (touch_q != {TIMER_BITS{1'b1}}) touch_d = touch_q + 1'b1;
          if (gap_q != {TIMER_BITS{1'b1}})   gap_d   = gap_q + 1'b1;
        end
        gtc_pkg::FUNC_X: if (cfg_i.record_enable) last_x_d = coord;
        gtc_pkg::FUNC_Y: if (cfg_i.record_enable) last_y_d = coord;
        gtc_pkg::FUNC_ID: begin
          if (cfg_i.record_enable) begin
            if (value_i != gtc_pkg::LIFT_ID) begin
              touching_d = 1'b1;
              down_x_d   = last_x_q;
              down_y_d   = last_y_q;
              touch_d    = '0;
            end else if (touching_q) begin
              touching_d = 1'b0;
              emit       = 1'b1;
              gap_d      = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (cfg_i.clear_gap) gap_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q   <= '0;
      last_y_q   <= '0;
      down_x_q   <= '0;
      down_y_q   <= '0;
      touching_q <= 1'b0;
      touch_q    <= '0;
      gap_q      <= '0;
    end else begin
      last_x_q   <= last_x_d;
      last_y_q   <= last_y_d;
      down_x_q   <= down_x_d;
      down_y_q   <= down_y_d;
      touching_q <= touching_d;
      touch_q    <= touch_d;
      gap_q      <= gap_d;
    end
  end

  assign res_valid_o = emit;
  assign res_kind_o  = kind;
  assign res_data_o  = {{PAD_W{1'b0}}, cfg_i.record_mode, gap_q, touch_q,
                        last_y_q, last_x_q, down_y_q, down_x_q};

endmodule

@@ design/gtc_out_stage.sv @@
`timescale 1ns / 1ps

module gtc_out_stage #(
  parameter int unsigned WIDTH = 122
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
